[hdl/tidt_pkg.sv]
// ----------------------------------------------------------------------------
// tidt_pkg
// Shared sizes, codes and types of the in-flight dedup table.
// ----------------------------------------------------------------------------
`default_nettype none

package tidt_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 64;
  localparam int TIME_W    = 32;
  localparam int ORD_W     = 32;
  localparam int LIM_W     = 5;
  localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int ENT_W     = KEY_W + TIME_W + ORD_W;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int IN_W      = KEY_W + TIME_W;
  localparam int OUT_W     = 8;

  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_TTL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DECIDE,
    S_OUT
  } tidt_state_t;

  typedef struct packed {
    logic             match_hit;
    logic             match_active;
    logic [IDX_W-1:0] match_idx;
    logic [CNT_W-1:0] count;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             pick_hit;
    logic [IDX_W-1:0] pick_idx;
  } tidt_scan_t;

endpackage

`default_nettype wire

[hdl/ttl_inflight_dedup_table.sv]
// ----------------------------------------------------------------------------
// ttl_inflight_dedup_table
// Admission gate for background work keyed by 64-bit tags, with retry ttl
// and in-flight dedup over a small slot table held in RAM.
// ----------------------------------------------------------------------------
// After accept, the block sweeps all slot RAM entries at one entry per cycle
// through the registered RAM read, then takes one decide/write-back step and
// one output load. The next item is accepted once that output load has put
// the block back in idle, so one item is worked at a time; a finished result
// waits in the output register while the next item is taken, and if that
// register still holds an untaken result when the next one is ready, the
// block holds in its output step until the receiver takes it.
// Slot valid bits are flip-flops cleared by reset, so no clearing pass is
// needed. opcode travels in in_tuser; end and query only read the table,
// except that end writes back the in-flight flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_inflight_dedup_table
  import tidt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // work_key[63:0], now_ticks[95:64]
  input  wire logic [OP_W-1:0]      in_tuser,   // opcode[1:0]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // granted[0], busy_res[1], zero[7:2]
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  tidt_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              rvld_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic              go_r;
  logic [TIME_W-1:0] ttl_r;
  logic [LIM_W-1:0]  limit_r;
  logic [DEPTH-1:0]  valid_r;
  logic [ORD_W-1:0]  order_r;
  logic              res_grant_r, res_busy_r;
  logic              out_valid_r, out_grant_r, out_busy_r;

  logic              in_acc;
  logic              rd_en;
  logic [CMP_W-1:0]  cap;
  logic              full;
  logic              dec_grant, dec_evict, dec_busy, dec_end_hit;
  logic [IDX_W-1:0]  dec_tgt;
  logic              out_load;
  logic              prune_clr;
  tidt_scan_t        scan;
  logic [ENT_W-1:0]  ent_rd;
  logic              act_rd;
  logic              ent_we, act_we, act_wd;
  logic [IDX_W-1:0]  act_waddr;
  logic [ORD_W-1:0]  order_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign rd_en     = (state_r == S_SWEEP) && (cnt_r != CNT_W'(DEPTH));
  assign cap       = (CMP_W'(limit_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(limit_r);
  assign full      = CMP_W'(scan.count) >= cap;
  assign order_inc = order_r + ORD_W'(1);

  always_comb begin
    dec_grant   = 1'b0;
    dec_evict   = 1'b0;
    dec_tgt     = scan.free_idx;
    if (go_r && !scan.match_hit) begin
      if (!full) begin
        dec_grant = scan.free_hit;
      end else if (scan.pick_hit) begin
        dec_grant = 1'b1;
        dec_evict = 1'b1;
        dec_tgt   = (scan.free_hit && scan.free_idx < scan.pick_idx) ?
                    scan.free_idx : scan.pick_idx;
      end
    end
    dec_busy    = (op_r == OP_QUERY) && (key_r != '0) &&
                  scan.match_hit && scan.match_active;
    dec_end_hit = (op_r == OP_END) && scan.match_hit;
  end

  assign ent_we    = (state_r == S_DECIDE) && dec_grant;
  assign act_we    = (state_r == S_DECIDE) && (dec_grant || dec_end_hit);
  assign act_wd    = dec_grant;
  assign act_waddr = dec_grant ? dec_tgt : scan.match_idx;

  tidt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (dec_tgt),
    .wdata ({key_r, now_r, order_inc}),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ent_rd)
  );

  tidt_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wd),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (act_rd)
  );

  tidt_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (in_acc),
    .vld        (rvld_r),
    .idx        (ridx_r),
    .slot_vld   (valid_r[ridx_r]),
    .ent        (ent_rd),
    .ent_active (act_rd),
    .prune_en   (go_r),
    .key        (key_r),
    .now        (now_r),
    .ttl        (ttl_r),
    .prune_clr  (prune_clr),
    .res        (scan)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) begin
        state_nxt = S_SWEEP;
      end
      S_SWEEP:  if (cnt_r == CNT_W'(DEPTH)) begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: state_nxt = S_OUT;
      S_OUT:    if (out_load) begin
        state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rvld_r      <= 1'b0;
      go_r        <= 1'b0;
      ttl_r       <= '0;
      limit_r     <= LIM_W'(16);
      valid_r     <= '0;
      order_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rvld_r <= rd_en;
      if (in_acc) begin
        cnt_r <= '0;
        go_r  <= (in_tuser == OP_BEGIN) && (in_tdata[KEY_W-1:0] != '0) && (cap != '0);
      end else if (rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RETRY_TTL:   ttl_r   <= cfg_data[TIME_W-1:0];
          REG_TABLE_LIMIT: limit_r <= cfg_data[LIM_W-1:0];
          default:         ;
        endcase
      end
      if (prune_clr) begin
        valid_r[ridx_r] <= 1'b0;
      end
      if (state_r == S_DECIDE) begin
        if (dec_evict && dec_tgt != scan.pick_idx) begin
          valid_r[scan.pick_idx] <= 1'b0;
        end
        if (dec_grant) begin
          valid_r[dec_tgt] <= 1'b1;
          order_r          <= order_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cnt_r[IDX_W-1:0];
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KEY_W-1:0];
      now_r <= in_tdata[KEY_W +: TIME_W];
    end
    if (state_r == S_DECIDE) begin
      res_grant_r <= dec_grant;
      res_busy_r  <= dec_busy;
    end
    if (out_load) begin
      out_grant_r <= res_grant_r;
      out_busy_r  <= res_busy_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-2){1'b0}}, out_busy_r, out_grant_r};

  a_grant_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("granted and busy_res both set");

  a_order_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && dec_grant) |=> order_r == $past(order_inc))
    else $error("order counter did not advance on grant");

  a_tgt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && dec_grant) |=> valid_r[$past(dec_tgt)])
    else $error("granted slot not marked valid");

  a_grant_begin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && dec_grant) |-> (op_r == OP_BEGIN && !scan.match_hit))
    else $error("grant outside a fresh try_begin");

endmodule

`default_nettype wire

[hdl/tidt_ram.sv]
// ----------------------------------------------------------------------------
// tidt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tidt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/tidt_scan.sv]
// ----------------------------------------------------------------------------
// tidt_scan
// Per-slot sweep: prunes expired entries, finds the key match, counts live
// slots, and tracks the lowest free slot and the oldest completed entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tidt_scan
  import tidt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clear,
  input  wire logic              vld,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic              slot_vld,
  input  wire logic [ENT_W-1:0]  ent,
  input  wire logic              ent_active,
  input  wire logic              prune_en,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [TIME_W-1:0] ttl,
  output logic                   prune_clr,
  output tidt_scan_t             res
);

  logic [KEY_W-1:0]  ent_key;
  logic [TIME_W-1:0] ent_time;
  logic [ORD_W-1:0]  ent_order;
  logic [TIME_W-1:0] age;
  logic              live;
  logic [ORD_W-1:0]  pick_order_r;
  tidt_scan_t        res_r;

  assign ent_key   = ent[ENT_W-1 -: KEY_W];
  assign ent_time  = ent[ORD_W +: TIME_W];
  assign ent_order = ent[ORD_W-1:0];
  assign age       = now - ent_time;
  assign prune_clr = vld && prune_en && slot_vld && !ent_active && (age >= ttl);
  assign live      = slot_vld && !prune_clr;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      res_r <= '0;
    end else if (vld) begin
      if (live && ent_key == key) begin
        res_r.match_hit    <= 1'b1;
        res_r.match_active <= ent_active;
        res_r.match_idx    <= idx;
      end
      if (live) begin
        res_r.count <= res_r.count + CNT_W'(1);
      end
      if (!live && !res_r.free_hit) begin
        res_r.free_hit <= 1'b1;
        res_r.free_idx <= idx;
      end
      if (live && !ent_active && (!res_r.pick_hit || ent_order < pick_order_r)) begin
        res_r.pick_hit <= 1'b1;
        res_r.pick_idx <= idx;
        pick_order_r   <= ent_order;
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire
